### rtl/lob_pkg.sv
// shared types and constants of the limit order book matcher
// no dependencies; used by lob_cell, lob_chain, the top level and the testbench

package lob_pkg;

  localparam int unsigned SLOTS_DEF   = 32;
  localparam int unsigned MAX_RESULTS = 64;
  localparam int unsigned KW          = $clog2(MAX_RESULTS);

  typedef enum logic [1:0] {
    TYPE_LIMIT  = 2'd0,
    TYPE_MARKET = 2'd1,
    TYPE_IOC    = 2'd2,
    TYPE_FOK    = 2'd3
  } otype_e;

  typedef enum logic [2:0] {
    OC_RESTED    = 3'd0,
    OC_FILLED    = 3'd1,
    OC_CANCELLED = 3'd2,
    OC_KILLED    = 3'd3,
    OC_BOOK_FULL = 3'd4
  } outcome_e;

  // one resting order
  typedef struct packed {
    logic        valid;
    logic [31:0] price;
    logic [31:0] qty;
    logic [31:0] id;
  } entry_t;

  // command broadcast along one side of the book
  typedef struct packed {
    logic shift;  // drop the head, all move one toward the head
    logic ins;    // sorted insert of the new order
    logic dec;    // reduce the head quantity
  } cmd_t;

endpackage

### rtl/lob_cell.sv
// one slot of a sorted book side: holds an order and a running liquidity sum
// depends on lob_pkg

module lob_cell #(
  parameter bit          IS_BID = 1'b1,
  parameter int unsigned SUM_W  = 38
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lob_pkg::cmd_t       cmd_i,
  input  logic [31:0]         x_i,
  input  logic [31:0]         new_qty_i,
  input  logic [31:0]         new_id_i,
  input  logic [31:0]         dec_amt_i,
  input  lob_pkg::entry_t     prev_i,
  input  lob_pkg::entry_t     next_i,
  input  logic                prev_keep_i,
  input  logic [SUM_W-1:0]    sum_i,
  output lob_pkg::entry_t     ent_o,
  output logic                keep_o,
  output logic [SUM_W-1:0]    sum_o
);

  lob_pkg::entry_t  ent_q, ent_d;
  logic [SUM_W-1:0] sum_q, sum_d;
  logic             keep;

  // entry stays ahead of x (and crosses a limit x on the opposite side)
  assign keep = ent_q.valid && (IS_BID ? (ent_q.price >= x_i) : (ent_q.price <= x_i));

  always_comb begin
    ent_d = ent_q;
    if (cmd_i.shift) begin
      ent_d = next_i;
    end else if (cmd_i.ins) begin
      if (!keep) begin
        if (prev_keep_i) begin
          ent_d.valid = 1'b1;
          ent_d.price = x_i;
          ent_d.qty   = new_qty_i;
          ent_d.id    = new_id_i;
        end else begin
          ent_d = prev_i;
        end
      end
    end else if (cmd_i.dec) begin
      ent_d.qty = ent_q.qty - dec_amt_i;
    end
    sum_d = sum_i + SUM_W'(keep ? ent_q.qty : 32'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_q <= '0;
      sum_q <= '0;
    end else begin
      ent_q <= ent_d;
      sum_q <= sum_d;
    end
  end

  assign ent_o  = ent_q;
  assign keep_o = keep;
  assign sum_o  = sum_q;

endmodule

### rtl/lob_chain.sv
// one side of the book as a row of lob_cell slots, best order at slot 0
// depends on lob_pkg and lob_cell

module lob_chain #(
  parameter bit          IS_BID = 1'b1,
  parameter int unsigned SLOTS  = lob_pkg::SLOTS_DEF,
  parameter int unsigned SUM_W  = 38
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  lob_pkg::cmd_t    cmd_i,
  input  logic [31:0]      x_i,
  input  logic [31:0]      new_qty_i,
  input  logic [31:0]      new_id_i,
  input  logic [31:0]      dec_amt_i,
  output lob_pkg::entry_t  head_o,
  output logic             head_keep_o,
  output logic [SUM_W-1:0] total_o
);

  lob_pkg::entry_t  ent  [SLOTS];
  logic             keep [SLOTS];
  logic [SUM_W-1:0] sum  [SLOTS];

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    lob_pkg::entry_t  prev_e, next_e;
    logic             prev_k;
    logic [SUM_W-1:0] sum_in;
    lob_pkg::cmd_t    cmd_c;

    if (i == 0) begin : g_first
      assign prev_e = '0;
      assign prev_k = 1'b1;
      assign sum_in = '0;
    end else begin : g_rest
      assign prev_e = ent[i-1];
      assign prev_k = keep[i-1];
      assign sum_in = sum[i-1];
    end
    if (i == SLOTS - 1) begin : g_end
      assign next_e = '0;
    end else begin : g_mid
      assign next_e = ent[i+1];
    end
    // only the head takes a partial fill
    assign cmd_c = '{shift: cmd_i.shift, ins: cmd_i.ins, dec: cmd_i.dec && (i == 0)};

    lob_cell #(.IS_BID(IS_BID), .SUM_W(SUM_W)) u_cell (
      .clk_i,
      .rst_ni,
      .cmd_i      (cmd_c),
      .x_i,
      .new_qty_i,
      .new_id_i,
      .dec_amt_i,
      .prev_i     (prev_e),
      .next_i     (next_e),
      .prev_keep_i(prev_k),
      .sum_i      (sum_in),
      .ent_o      (ent[i]),
      .keep_o     (keep[i]),
      .sum_o      (sum[i])
    );
  end

  assign head_o      = ent[0];
  assign head_keep_o = keep[0];
  assign total_o     = sum[SLOTS-1];

endmodule

### rtl/limit_order_book_matcher_core.sv
// top level of the price-time priority limit order book matcher
// depends on lob_pkg, lob_chain and lob_cell
//
// channel   dir  tdata (low bit first)                         tuser            tlast
// s_axis    in   order_id, limit_price, order_qty (96 bits)    side, order_type -
// m_axis    out  resting_id, incoming_id, trade_price, amount, is_status        last
//                outcome, zero pad (136 bits)
//
// one order at a time: accept, then a liquidity scan for fill-or-kill orders, the
// book full check, then one trade word per cycle while m_axis does not stall and
// a final status word
// reset clears every slot valid bit and the resting count at once, no clearing pass
// a stalled m_axis holds the sequencer; the output register frees the last word
// slot while the block takes the next order

module limit_order_book_matcher_core #(
  parameter int unsigned ORDER_SLOTS = lob_pkg::SLOTS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [95:0]  s_axis_tdata_i,   // order_id, limit_price, order_qty
  input  logic [2:0]   s_axis_tuser_i,   // side, order_type
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [135:0] m_axis_tdata_o,   // resting_id, incoming_id, trade_price, amount, outcome
  output logic         m_axis_tuser_o,   // is_status
  output logic         m_axis_tlast_o
);

  localparam int unsigned CNT_W = $clog2(ORDER_SLOTS + 1);
  localparam int unsigned SUM_W = 32 + CNT_W;
  localparam int unsigned KW    = lob_pkg::KW;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_ENTRY = 4'b0100,
    ST_MATCH = 4'b1000
  } state_e;

  state_e              state_q, state_d;
  logic [31:0]         id_q, id_d, lim_q, lim_d, rem_q, rem_d;
  logic                buy_q, buy_d;
  lob_pkg::otype_e     type_q, type_d;
  logic [KW-1:0]       k_q, k_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d, count_q, count_d;

  // output register
  logic                ov_q, ov_d, ost_q, ost_d;
  logic [31:0]         orid_q, orid_d, oiid_q, oiid_d, opr_q, opr_d, oamt_q, oamt_d;
  lob_pkg::outcome_e   ooc_q, ooc_d;
  logic                out_free;

  lob_pkg::cmd_t       bid_cmd, ask_cmd;
  lob_pkg::entry_t     bid_head, ask_head, head;
  logic                bid_hk, ask_hk, hkeep;
  logic [SUM_W-1:0]    bid_total, ask_total, total;
  logic [31:0]         t;
  logic                can_trade, market;

  lob_chain #(.IS_BID(1'b1), .SLOTS(ORDER_SLOTS), .SUM_W(SUM_W)) u_bids (
    .clk_i, .rst_ni, .cmd_i(bid_cmd), .x_i(lim_q), .new_qty_i(rem_q), .new_id_i(id_q),
    .dec_amt_i(t), .head_o(bid_head), .head_keep_o(bid_hk), .total_o(bid_total)
  );

  lob_chain #(.IS_BID(1'b0), .SLOTS(ORDER_SLOTS), .SUM_W(SUM_W)) u_asks (
    .clk_i, .rst_ni, .cmd_i(ask_cmd), .x_i(lim_q), .new_qty_i(rem_q), .new_id_i(id_q),
    .dec_amt_i(t), .head_o(ask_head), .head_keep_o(ask_hk), .total_o(ask_total)
  );

  // the opposite side is the one matched against
  assign head      = buy_q ? ask_head  : bid_head;
  assign hkeep     = buy_q ? ask_hk    : bid_hk;
  assign total     = buy_q ? ask_total : bid_total;
  assign market    = (type_q == lob_pkg::TYPE_MARKET);
  assign t         = (rem_q < head.qty) ? rem_q : head.qty;
  assign can_trade = (rem_q != 32'd0) && head.valid && (market || hkeep)
                     && (k_q != KW'(lob_pkg::MAX_RESULTS - 1));
  assign out_free  = !ov_q || m_axis_tready_i;

  always_comb begin
    state_d = state_q;
    id_d    = id_q;
    lim_d   = lim_q;
    rem_d   = rem_q;
    buy_d   = buy_q;
    type_d  = type_q;
    k_d     = k_q;
    cnt_d   = cnt_q;
    count_d = count_q;
    ov_d    = ov_q && !m_axis_tready_i;
    ost_d   = ost_q;
    orid_d  = orid_q;
    oiid_d  = oiid_q;
    opr_d   = opr_q;
    oamt_d  = oamt_q;
    ooc_d   = ooc_q;
    bid_cmd = '0;
    ask_cmd = '0;
    s_axis_tready_o = 1'b0;

    case (state_q)
      ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) begin
          id_d    = s_axis_tdata_i[31:0];
          lim_d   = s_axis_tdata_i[63:32];
          rem_d   = s_axis_tdata_i[95:64];
          buy_d   = !s_axis_tuser_i[0];
          type_d  = lob_pkg::otype_e'(s_axis_tuser_i[2:1]);
          k_d     = '0;
          cnt_d   = '0;
          state_d = (lob_pkg::otype_e'(s_axis_tuser_i[2:1]) == lob_pkg::TYPE_FOK)
                    ? ST_SCAN : ST_ENTRY;
        end
      end
      ST_SCAN: begin
        // wait until the sum wave has reached the last slot
        if (cnt_q == CNT_W'(ORDER_SLOTS)) begin
          if (total < SUM_W'(rem_q)) begin
            if (out_free) begin
              ov_d = 1'b1; ost_d = 1'b1; orid_d = '0; oiid_d = id_q; opr_d = '0;
              oamt_d = rem_q; ooc_d = lob_pkg::OC_KILLED;
              state_d = ST_IDLE;
            end
          end else begin
            state_d = ST_ENTRY;
          end
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_ENTRY: begin
        if (count_q >= CNT_W'(ORDER_SLOTS)) begin
          if (out_free) begin
            ov_d = 1'b1; ost_d = 1'b1; orid_d = '0; oiid_d = id_q; opr_d = '0;
            oamt_d = rem_q; ooc_d = lob_pkg::OC_BOOK_FULL;
            state_d = ST_IDLE;
          end
        end else begin
          state_d = ST_MATCH;
        end
      end
      ST_MATCH: begin
        if (out_free) begin
          ov_d   = 1'b1;
          oiid_d = id_q;
          if (can_trade) begin
            ost_d  = 1'b0; orid_d = head.id; opr_d = head.price; oamt_d = t;
            ooc_d  = lob_pkg::OC_RESTED;
            rem_d  = rem_q - t;
            k_d    = k_q + 1'b1;
            if (t == head.qty) begin
              if (buy_q) ask_cmd.shift = 1'b1; else bid_cmd.shift = 1'b1;
              count_d = count_q - 1'b1;
            end else begin
              if (buy_q) ask_cmd.dec = 1'b1; else bid_cmd.dec = 1'b1;
            end
          end else begin
            ost_d  = 1'b1; orid_d = '0; opr_d = '0; oamt_d = rem_q;
            state_d = ST_IDLE;
            if (rem_q == 32'd0) begin
              ooc_d = lob_pkg::OC_FILLED;
            end else if (type_q == lob_pkg::TYPE_LIMIT) begin
              ooc_d = lob_pkg::OC_RESTED;
              if (buy_q) bid_cmd.ins = 1'b1; else ask_cmd.ins = 1'b1;
              count_d = count_q + 1'b1;
            end else begin
              ooc_d = lob_pkg::OC_CANCELLED;
            end
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q   <= id_d;
    lim_q  <= lim_d;
    rem_q  <= rem_d;
    buy_q  <= buy_d;
    type_q <= type_d;
    k_q    <= k_d;
    cnt_q  <= cnt_d;
    ost_q  <= ost_d;
    orid_q <= orid_d;
    oiid_q <= oiid_d;
    opr_q  <= opr_d;
    oamt_q <= oamt_d;
    ooc_q  <= ooc_d;
  end

  assign m_axis_tvalid_o = ov_q;
  assign m_axis_tuser_o  = ost_q;
  assign m_axis_tlast_o  = ost_q;
  assign m_axis_tdata_o  = {5'd0, ooc_q, oamt_q, opr_q, oiid_q, orid_q};

endmodule

### rtl/lob_checker.sv
// port-level checks of the order book matcher, bound to the top level
// depends only on the top level's ports

module lob_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid_i,
  input logic         s_axis_tready_o,
  input logic         m_axis_tvalid_o,
  input logic         m_axis_tready_i,
  input logic [135:0] m_axis_tdata_o,
  input logic         m_axis_tuser_o,
  input logic         m_axis_tlast_o
);

  // one order at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("ready stayed high after an order was taken");

  // only the status word closes a run
  a_last_is_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tlast_o == m_axis_tuser_o))
    else $error("tlast and status flag disagree");

  // status words carry no resting id and no price
  a_status_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |->
      (m_axis_tdata_o[31:0] == 32'd0) && (m_axis_tdata_o[95:64] == 32'd0))
    else $error("status word with trade fields set");

  // a trade always moves a nonzero amount and has outcome zero
  a_trade_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o |->
      (m_axis_tdata_o[127:96] != 32'd0) && (m_axis_tdata_o[130:128] == 3'd0))
    else $error("bad trade word");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("output word changed while stalled");

endmodule

bind limit_order_book_matcher_core lob_checker u_lob_checker (.*);

### tb/tb_limit_order_book_matcher_core.sv
// testbench of the limit order book matcher: drives orders on s_axis, predicts
// trades and status words, checks every m_axis word; depends on lob_pkg and the rtl

module tb_limit_order_book_matcher_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SLOTS = lob_pkg::SLOTS_DEF;
  localparam longint CYCLE_LIMIT = 2000000;
  localparam int EXP_DEPTH = 256;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [95:0]  s_axis_tdata_i = '0;
  logic [2:0]   s_axis_tuser_i = '0;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic [135:0] m_axis_tdata_o;
  logic         m_axis_tuser_o;
  logic         m_axis_tlast_o;

  limit_order_book_matcher_core #(.ORDER_SLOTS(SLOTS)) dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // one output word as predicted
  typedef struct packed {
    logic              is_status;
    logic [31:0]       resting_id;
    logic [31:0]       incoming_id;
    logic [31:0]       trade_price;
    logic [31:0]       amount;
    lob_pkg::outcome_e outcome;
    logic              last;
  } fill_t;

  // predicted words in order, written at wr_ptr and read at rd_ptr
  fill_t exp_mem [EXP_DEPTH];
  int    wr_ptr = 0;
  int    rd_ptr = 0;

  // predictor copy of both book sides, slot 0 is best
  logic        bk_v  [2][SLOTS];
  logic [31:0] bk_p  [2][SLOTS];
  logic [31:0] bk_q  [2][SLOTS];
  logic [31:0] bk_id [2][SLOTS];
  int unsigned book_count;

  int  errors = 0;
  int  orders_sent = 0;
  int  words_seen = 0;
  int  trades_seen = 0;
  bit  quiet = 1'b0;   // no idling in the last part
  longint cycles = 0;

  task automatic report(input string what, input fill_t got, input fill_t exp);
    errors++;
    $display("mismatch %0s: got %h exp %h", what, got, exp);
  endtask

  function automatic void exp_put(fill_t f);
    exp_mem[wr_ptr % EXP_DEPTH] = f;
    wr_ptr++;
  endfunction

  function automatic fill_t mk(logic st, logic [31:0] rid, logic [31:0] iid,
                               logic [31:0] pr, logic [31:0] amt,
                               lob_pkg::outcome_e oc);
    fill_t f;
    f.is_status = st; f.resting_id = rid; f.incoming_id = iid;
    f.trade_price = pr; f.amount = amt; f.outcome = oc; f.last = st;
    return f;
  endfunction

  function automatic bit crosses(bit buy, logic [31:0] rp, logic [31:0] lim);
    return buy ? (rp <= lim) : (rp >= lim);
  endfunction

  // match one order against the book and queue the words it causes
  function automatic void predict_order(logic [31:0] oid, logic sd, lob_pkg::otype_e ty,
                                        logic [31:0] lim, logic [31:0] qty);
    bit buy;
    int o, me, n, pos, k;
    logic [63:0] liq;
    logic [31:0] t;
    buy = (sd == 1'b0);
    o = buy ? 1 : 0;   // index 0 bids, 1 asks
    me = buy ? 0 : 1;
    k = 0;
    if (ty == lob_pkg::TYPE_FOK) begin
      liq = 0;
      for (int i = 0; i < SLOTS && liq < qty; i++) begin
        if (!bk_v[o][i] || !crosses(buy, bk_p[o][i], lim)) break;
        liq += bk_q[o][i];
      end
      if (liq < qty) begin
        exp_put(mk(1, 0, oid, 0, qty, lob_pkg::OC_KILLED));
        return;
      end
    end
    if (book_count >= SLOTS) begin
      exp_put(mk(1, 0, oid, 0, qty, lob_pkg::OC_BOOK_FULL));
      return;
    end
    while (qty > 0 && bk_v[o][0]
           && (ty == lob_pkg::TYPE_MARKET || crosses(buy, bk_p[o][0], lim))
           && k < lob_pkg::MAX_RESULTS - 1) begin
      t = (qty < bk_q[o][0]) ? qty : bk_q[o][0];
      exp_put(mk(0, bk_id[o][0], oid, bk_p[o][0], t, lob_pkg::OC_RESTED));
      k++;
      qty -= t;
      bk_q[o][0] -= t;
      if (bk_q[o][0] == 0) begin
        for (int i = 0; i < SLOTS - 1; i++) begin
          bk_v[o][i] = bk_v[o][i+1]; bk_p[o][i] = bk_p[o][i+1];
          bk_q[o][i] = bk_q[o][i+1]; bk_id[o][i] = bk_id[o][i+1];
        end
        bk_v[o][SLOTS-1] = 0;
        if (book_count > 0) book_count--;
      end
    end
    if (qty == 0) exp_put(mk(1, 0, oid, 0, 0, lob_pkg::OC_FILLED));
    else if (ty == lob_pkg::TYPE_LIMIT) begin
      n = 0;
      for (int i = 0; i < SLOTS; i++) if (bk_v[me][i]) n++;
      if (n < SLOTS) begin
        pos = 0;
        while (pos < n && !(buy ? (bk_p[me][pos] < lim) : (bk_p[me][pos] > lim))) pos++;
        for (int i = n; i > pos; i--) begin
          bk_v[me][i] = bk_v[me][i-1]; bk_p[me][i] = bk_p[me][i-1];
          bk_q[me][i] = bk_q[me][i-1]; bk_id[me][i] = bk_id[me][i-1];
        end
        bk_v[me][pos] = 1; bk_p[me][pos] = lim; bk_q[me][pos] = qty;
        bk_id[me][pos] = oid;
        book_count++;
      end
      exp_put(mk(1, 0, oid, 0, qty, lob_pkg::OC_RESTED));
    end else exp_put(mk(1, 0, oid, 0, qty, lob_pkg::OC_CANCELLED));
  endfunction

  // send one order word, at times after a random idle burst
  task automatic send_order(logic [31:0] oid, logic sd, lob_pkg::otype_e ty,
                            logic [31:0] lim, logic [31:0] qty);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {qty, lim, oid};
    s_axis_tuser_i  <= {ty, sd};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    predict_order(oid, sd, ty, lim, qty);
    orders_sent++;
  endtask

  // receiver stalls in bursts
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (hold > 0) begin
        hold--;
        m_axis_tready_i <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        hold = $urandom_range(1, 14) - 1;
        m_axis_tready_i <= 1'b0;
      end else m_axis_tready_i <= 1'b1;
    end
  end

  // checker: compare each accepted word with the oldest prediction
  always @(posedge clk_i) begin
    fill_t got, exp;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.is_status   = m_axis_tuser_o;
      got.resting_id  = m_axis_tdata_o[31:0];
      got.incoming_id = m_axis_tdata_o[63:32];
      got.trade_price = m_axis_tdata_o[95:64];
      got.amount      = m_axis_tdata_o[127:96];
      got.outcome     = lob_pkg::outcome_e'(m_axis_tdata_o[130:128]);
      got.last        = m_axis_tlast_o;
      words_seen++;
      if (!got.is_status) trades_seen++;
      if (wr_ptr == rd_ptr) report("unexpected word", got, got);
      else begin
        exp = exp_mem[rd_ptr % EXP_DEPTH];
        rd_ptr++;
        if (got.is_status   !== exp.is_status)   report("is_status", got, exp);
        if (got.resting_id  !== exp.resting_id)  report("resting_id", got, exp);
        if (got.incoming_id !== exp.incoming_id) report("incoming_id", got, exp);
        if (got.trade_price !== exp.trade_price) report("trade_price", got, exp);
        if (got.amount      !== exp.amount)      report("amount", got, exp);
        if (got.outcome     !== exp.outcome)     report("outcome", got, exp);
        if (got.last        !== exp.last)        report("last", got, exp);
        if (m_axis_tdata_o[135:131] !== '0)      report("pad bits", got, exp);
      end
    end
  end

  // cycle limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb_limit_order_book_matcher_core: FAIL");
      $finish;
    end
  end

  int unsigned next_id = 1;
  function automatic logic [31:0] fresh_id();
    next_id++;
    return next_id;
  endfunction

  // special cases: zero qty, market with empty book, fok short, extremes
  task automatic test_directed();
    send_order(32'hFFFF_FFFF, 0, lob_pkg::TYPE_LIMIT, 32'hFFFF_FFFF, 0);
    send_order(fresh_id(), 1, lob_pkg::TYPE_MARKET, 0, 5);
    send_order(fresh_id(), 0, lob_pkg::TYPE_FOK, 100, 1);
    send_order(fresh_id(), 0, lob_pkg::TYPE_FOK, 100, 0);
    send_order(fresh_id(), 1, lob_pkg::TYPE_LIMIT, 100, 10);
    send_order(fresh_id(), 1, lob_pkg::TYPE_LIMIT, 100, 7);
    send_order(fresh_id(), 1, lob_pkg::TYPE_LIMIT, 90, 3);
    send_order(fresh_id(), 1, lob_pkg::TYPE_LIMIT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_order(fresh_id(), 0, lob_pkg::TYPE_FOK, 100, 21);
    send_order(fresh_id(), 0, lob_pkg::TYPE_FOK, 100, 20);
    send_order(fresh_id(), 0, lob_pkg::TYPE_IOC, 32'hFFFF_FFFE, 5);
    send_order(fresh_id(), 0, lob_pkg::TYPE_MARKET, 0, 32'hFFFF_FFFF);
    send_order(fresh_id(), 0, lob_pkg::TYPE_LIMIT, 0, 32'hFFFF_FFFF);
    send_order(0, 1, lob_pkg::TYPE_MARKET, 0, 32'h8000_0000);
    send_order(fresh_id(), 1, lob_pkg::TYPE_IOC, 50, 9);
  endtask

  // fill one side until the book is full, then hit the full check
  task automatic test_book_full();
    while (book_count < SLOTS)
      send_order(fresh_id(), 0, lob_pkg::TYPE_LIMIT, $urandom_range(1, 40),
                 $urandom_range(1, 9));
    send_order(fresh_id(), 0, lob_pkg::TYPE_LIMIT, 10, 3);
    send_order(fresh_id(), 1, lob_pkg::TYPE_MARKET, 0, 1);
    send_order(fresh_id(), 1, lob_pkg::TYPE_FOK, 32'hFFFF_FFFF, 2);
    send_order(fresh_id(), 1, lob_pkg::TYPE_FOK, 0, 0);
    // large market sell against the full book
    send_order(fresh_id(), 1, lob_pkg::TYPE_MARKET, 0, 32'hFFFF_FFFF);
  endtask

  // random orders around a narrow price band so they cross often
  task automatic test_random(input int count);
    logic [31:0] lim, qty, oid;
    lob_pkg::otype_e ty;
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 19);
      ty = lob_pkg::otype_e'($urandom_range(0, 3));
      if (r < 9) ty = lob_pkg::TYPE_LIMIT;
      lim = (r == 19) ? $urandom : 1000 + $urandom_range(0, 20);
      qty = (r == 18) ? $urandom : $urandom_range(0, 60);
      oid = (r == 17) ? $urandom : fresh_id();
      send_order(oid, $urandom_range(0, 1), ty, lim, qty);
    end
  endtask

  initial begin
    for (int s = 0; s < 2; s++)
      for (int i = 0; i < SLOTS; i++) begin
        bk_v[s][i] = 0; bk_p[s][i] = 0; bk_q[s][i] = 0; bk_id[s][i] = 0;
      end
    book_count = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_book_full();
    test_random(80);
    quiet = 1'b1;
    test_random(20);
    s_axis_tvalid_i <= 1'b0;
    while (wr_ptr != rd_ptr) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    $display("sent %0d orders, checked %0d words (%0d trades), book full and fok paths hit",
             orders_sent, words_seen, trades_seen);
    if (errors == 0 && wr_ptr == rd_ptr) begin
      $display("tb_limit_order_book_matcher_core: PASS");
    end else begin
      $display("tb_limit_order_book_matcher_core: FAIL");
    end
    $finish;
  end

endmodule
